>>> design/srrip_pkg.sv
// shared constants and types for the segmented rrip replacement unit
package srrip_pkg;

    localparam int NUM_SETS   = 2048;
    localparam int SET_W      = $clog2(NUM_SETS);
    localparam int NUM_WAYS   = 16;
    localparam int WAY_W      = $clog2(NUM_WAYS);
    localparam int HIST_DEPTH = 8;
    localparam int HIST_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int LOC_W      = WAY_W + 1;
    localparam int INIT_LOC   = 6;
    localparam int PAGE_W     = 16;
    localparam int PTR_W      = 8;
    localparam int STAMP_W    = 64;

    localparam logic [1:0] RRPV_TOP = 2'd3;

    // command codes
    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_INSERT_RRPV = 3'd0;
    localparam logic [2:0] CFG_GROW_PCT    = 3'd1;
    localparam logic [2:0] CFG_SHRINK_PCT  = 3'd2;
    localparam logic [2:0] CFG_PERIOD_LOG2 = 3'd3;
    localparam logic [2:0] CFG_MIN_LOC     = 3'd4;

    typedef struct packed {
        logic [1:0]         rrpv;
        logic [STAMP_W-1:0] stamp;
        logic               mark;
    } way_meta_t;

    typedef way_meta_t [NUM_WAYS-1:0] way_row_t;

    typedef struct packed {
        logic [HIST_DEPTH-1:0][PAGE_W-1:0] page;
        logic [HIST_DEPTH-1:0][PTR_W-1:0]  ptr;
        logic [HIST_DEPTH-1:0]             ptr_valid;
        logic [HIST_W-1:0]                 slot;
        logic [LOC_W-1:0]                  seg_ways;
    } set_meta_t;

endpackage

>>> design/srrip_ram.sv
// generic single-write, single-read synchronous ram with a registered read port
module srrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/srrip_hist.sv
// history match and history ring update for one set
module srrip_hist
    import srrip_pkg::*;
(
    input  set_meta_t         set_in,
    input  logic [PAGE_W-1:0] page,
    input  logic [PTR_W-1:0]  ptr,
    output logic              loc,
    output set_meta_t         set_out
);

    // compare against every history slot
    always_comb
    begin
        loc = 1'b0;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            if (set_in.page[i] == page)
            begin
                loc = 1'b1;
            end
            if (set_in.ptr_valid[i] && (set_in.ptr[i] == ptr))
            begin
                loc = 1'b1;
            end
        end
    end

    // write both tags at the ring slot and advance it
    always_comb
    begin
        set_out = set_in;
        set_out.page[set_in.slot]      = page;
        set_out.ptr[set_in.slot]       = ptr;
        set_out.ptr_valid[set_in.slot] = 1'b1;
        if (set_in.slot == HIST_W'(HIST_DEPTH - 1))
        begin
            set_out.slot = '0;
        end
        else
        begin
            set_out.slot = set_in.slot + HIST_W'(1);
        end
    end

endmodule

>>> design/segmented_rrip_cache_replacement_unit.sv
// top level of the segmented rrip replacement unit
// After reset the unit sweeps both set memories to their reset contents, one set per
// cycle, and holds in_stall high meanwhile; configuration writes are taken at any time.
// Each item then reads its set's way row and history row from the two memories
// together and writes them back at the end, one item at a time. A query that finds a
// way with the top RRPV, before or after aging, goes straight to the write-back; one
// that falls back to the oldest stamp first scans all 16 ways, one way per cycle. An
// update applies the access and, when the block changes segment, scans that segment
// for its oldest way and swaps with it; it then checks the segment boundary and writes
// back. A query waits at the write-back until the output register can take its result.
module segmented_rrip_cache_replacement_unit
    import srrip_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [SET_W-1:0]   set_index,
    input  logic [WAY_W-1:0]   way_index,
    input  logic [63:0]        phys_address,
    input  logic               was_hit,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [WAY_W-1:0]   victim_way,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [6:0]         cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_QUERY,
        S_UPDATE,
        S_SCAN,
        S_SWAP,
        S_ADJUST,
        S_WRITE
    } state_t;

    state_t             state_reg;
    logic [SET_W-1:0]   clr_idx_reg;

    logic               cmd_reg;
    logic [SET_W-1:0]   set_reg;
    logic [WAY_W-1:0]   way_reg;
    logic [63:0]        addr_reg;
    logic               hit_reg;

    way_row_t           row_reg;
    set_meta_t          meta_reg;

    logic [WAY_W-1:0]   best_reg;
    logic [LOC_W-1:0]   scan_idx_reg;
    logic [LOC_W-1:0]   scan_hi_reg;
    logic [WAY_W-1:0]   victim_reg;

    logic               out_valid_reg;
    logic [WAY_W-1:0]   victim_way_reg;

    logic [STAMP_W-1:0] access_count_reg;
    logic [31:0]        loc_hits_reg;
    logic [31:0]        gen_hits_reg;

    logic [1:0]         insert_rrpv_reg;
    logic [6:0]         grow_pct_reg;
    logic [6:0]         shrink_pct_reg;
    logic [4:0]         period_log2_reg;
    logic [2:0]         min_loc_reg;

    way_row_t           way_rd;
    set_meta_t          meta_rd;
    way_row_t           row_rst;
    set_meta_t          meta_rst;
    logic               mem_wr;
    logic [SET_W-1:0]   mem_wr_addr;
    way_row_t           way_wr_data;
    set_meta_t          meta_wr_data;
    logic               mem_rd;

    logic               loc;
    set_meta_t          meta_hist;
    logic [LOC_W-1:0]   l_eff;
    way_row_t           aged_row;
    way_row_t           upd_row;
    way_row_t           swap_row;
    logic [WAY_W:0]     top_pick;
    logic [WAY_W:0]     aged_pick;
    logic               scan_less;
    logic [STAMP_W-1:0] period_mask;
    logic [32:0]        hit_total;
    logic [39:0]        loc_scaled;
    logic [39:0]        grow_scaled;
    logic [39:0]        shrink_scaled;
    logic [LOC_W-1:0]   way_ext;
    logic               out_load;

    // first way with the top rrpv, general segment before locality segment
    function automatic logic [WAY_W:0] find_top(way_row_t r, logic [LOC_W-1:0] l);
        logic             gen_f;
        logic             loc_f;
        logic [WAY_W-1:0] gen_w;
        logic [WAY_W-1:0] loc_w;
        gen_f = 1'b0;
        loc_f = 1'b0;
        gen_w = '0;
        loc_w = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (r[w].rrpv == RRPV_TOP)
            begin
                if (LOC_W'(w) >= l)
                begin
                    gen_f = 1'b1;
                    gen_w = WAY_W'(w);
                end
                else
                begin
                    loc_f = 1'b1;
                    loc_w = WAY_W'(w);
                end
            end
        end
        return gen_f ? {1'b1, gen_w} : {loc_f, loc_w};
    endfunction

    // reset contents of one set
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            row_rst[w].rrpv  = RRPV_TOP;
            row_rst[w].stamp = '0;
            row_rst[w].mark  = 1'b0;
        end
        meta_rst          = '0;
        meta_rst.seg_ways = LOC_W'(INIT_LOC);
    end

    // memory ports
    assign mem_rd       = (state_reg == S_IDLE) && in_valid;
    assign mem_wr       = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
    assign mem_wr_addr  = (state_reg == S_CLEAR) ? clr_idx_reg : set_reg;
    assign way_wr_data  = (state_reg == S_CLEAR) ? row_rst : row_reg;
    assign meta_wr_data = (state_reg == S_CLEAR) ? meta_rst : meta_reg;

    srrip_ram #(
        .WIDTH ($bits(way_row_t)),
        .DEPTH (NUM_SETS)
    ) u_way_ram (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (mem_wr_addr),
        .wr_data (way_wr_data),
        .rd_en   (mem_rd),
        .rd_addr (set_index),
        .rd_data (way_rd)
    );

    srrip_ram #(
        .WIDTH ($bits(set_meta_t)),
        .DEPTH (NUM_SETS)
    ) u_meta_ram (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (mem_wr_addr),
        .wr_data (meta_wr_data),
        .rd_en   (mem_rd),
        .rd_addr (set_index),
        .rd_data (meta_rd)
    );

    // locality classification
    srrip_hist u_hist (
        .set_in  (meta_reg),
        .page    (addr_reg[27:12]),
        .ptr     (addr_reg[10:3]),
        .loc     (loc),
        .set_out (meta_hist)
    );

    // victim search and aging
    always_comb
    begin
        l_eff = (meta_reg.seg_ways > LOC_W'(NUM_WAYS)) ? LOC_W'(NUM_WAYS) : meta_reg.seg_ways;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            aged_row[w] = row_reg[w];
            if (row_reg[w].rrpv != RRPV_TOP)
            begin
                aged_row[w].rrpv = row_reg[w].rrpv + 2'd1;
            end
        end
        top_pick  = find_top(row_reg, l_eff);
        aged_pick = find_top(aged_row, l_eff);
        scan_less = row_reg[scan_idx_reg[WAY_W-1:0]].stamp < row_reg[best_reg].stamp;
        way_ext   = {1'b0, way_reg};
    end

    // row after the access itself and row after the segment swap
    always_comb
    begin
        upd_row                  = row_reg;
        upd_row[way_reg].rrpv    = hit_reg ? 2'd0 : insert_rrpv_reg;
        upd_row[way_reg].stamp   = access_count_reg + STAMP_W'(1);
        upd_row[way_reg].mark    = loc;
        swap_row                 = row_reg;
        swap_row[way_reg]        = row_reg[best_reg];
        swap_row[best_reg]       = row_reg[way_reg];
    end

    // boundary check arithmetic
    always_comb
    begin
        period_mask   = ~({STAMP_W{1'b1}} << period_log2_reg);
        hit_total     = {1'b0, loc_hits_reg} + {1'b0, gen_hits_reg};
        loc_scaled    = {8'b0, loc_hits_reg} * 40'd100;
        grow_scaled   = {33'b0, grow_pct_reg} * {7'b0, hit_total};
        shrink_scaled = {33'b0, shrink_pct_reg} * {7'b0, hit_total};
    end

    // a query result enters the output register
    assign out_load = (state_reg == S_WRITE) && (cmd_reg == CMD_QUERY) &&
                      (!out_valid_reg || !out_stall);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            insert_rrpv_reg <= 2'd2;
            grow_pct_reg    <= 7'd70;
            shrink_pct_reg  <= 7'd30;
            period_log2_reg <= 5'd12;
            min_loc_reg     <= 3'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INSERT_RRPV: insert_rrpv_reg <= cfg_data[1:0];
                CFG_GROW_PCT:    grow_pct_reg    <= cfg_data;
                CFG_SHRINK_PCT:  shrink_pct_reg  <= cfg_data;
                CFG_PERIOD_LOG2: period_log2_reg <= cfg_data[4:0];
                CFG_MIN_LOC:     min_loc_reg     <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_idx_reg      <= '0;
            cmd_reg          <= CMD_QUERY;
            set_reg          <= '0;
            way_reg          <= '0;
            addr_reg         <= '0;
            hit_reg          <= 1'b0;
            row_reg          <= '0;
            meta_reg         <= '0;
            best_reg         <= '0;
            scan_idx_reg     <= '0;
            scan_hi_reg      <= '0;
            victim_reg       <= '0;
            out_valid_reg    <= 1'b0;
            victim_way_reg   <= '0;
            access_count_reg <= '0;
            loc_hits_reg     <= '0;
            gen_hits_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + SET_W'(1);
                    if (clr_idx_reg == SET_W'(NUM_SETS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg   <= command;
                        set_reg   <= set_index;
                        way_reg   <= way_index;
                        addr_reg  <= phys_address;
                        hit_reg   <= was_hit;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    row_reg   <= way_rd;
                    meta_reg  <= meta_rd;
                    state_reg <= (cmd_reg == CMD_UPDATE) ? S_UPDATE : S_QUERY;
                end
                S_QUERY:
                begin
                    access_count_reg <= access_count_reg + STAMP_W'(1);
                    if (top_pick[WAY_W])
                    begin
                        victim_reg <= top_pick[WAY_W-1:0];
                        state_reg  <= S_WRITE;
                    end
                    else
                    begin
                        row_reg <= aged_row;
                        if (aged_pick[WAY_W])
                        begin
                            victim_reg <= aged_pick[WAY_W-1:0];
                            state_reg  <= S_WRITE;
                        end
                        else
                        begin
                            best_reg     <= '0;
                            scan_idx_reg <= LOC_W'(1);
                            scan_hi_reg  <= LOC_W'(NUM_WAYS);
                            state_reg    <= S_SCAN;
                        end
                    end
                end
                S_UPDATE:
                begin
                    access_count_reg <= access_count_reg + STAMP_W'(1);
                    meta_reg         <= meta_hist;
                    row_reg          <= upd_row;
                    if (hit_reg && loc)
                    begin
                        loc_hits_reg <= loc_hits_reg + 32'd1;
                    end
                    if (hit_reg && !loc)
                    begin
                        gen_hits_reg <= gen_hits_reg + 32'd1;
                    end
                    // move into the segment that matches the class
                    if (loc && (way_ext >= l_eff) && (l_eff != '0))
                    begin
                        best_reg     <= '0;
                        scan_idx_reg <= LOC_W'(1);
                        scan_hi_reg  <= l_eff;
                        state_reg    <= S_SCAN;
                    end
                    else if (!loc && (way_ext < l_eff) && (l_eff != LOC_W'(NUM_WAYS)))
                    begin
                        best_reg     <= l_eff[WAY_W-1:0];
                        scan_idx_reg <= l_eff + LOC_W'(1);
                        scan_hi_reg  <= LOC_W'(NUM_WAYS);
                        state_reg    <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_ADJUST;
                    end
                end
                S_SCAN:
                begin
                    // oldest stamp, one way per cycle, lowest way wins a tie
                    if (scan_idx_reg < scan_hi_reg)
                    begin
                        if (scan_less)
                        begin
                            best_reg <= scan_idx_reg[WAY_W-1:0];
                        end
                        scan_idx_reg <= scan_idx_reg + LOC_W'(1);
                    end
                    else if (cmd_reg == CMD_QUERY)
                    begin
                        victim_reg <= best_reg;
                        state_reg  <= S_WRITE;
                    end
                    else
                    begin
                        state_reg <= S_SWAP;
                    end
                end
                S_SWAP:
                begin
                    row_reg   <= swap_row;
                    state_reg <= S_ADJUST;
                end
                S_ADJUST:
                begin
                    if ((access_count_reg & period_mask) == '0)
                    begin
                        if (hit_total != '0)
                        begin
                            if ((loc_scaled > grow_scaled) &&
                                (meta_reg.seg_ways < (LOC_W'(NUM_WAYS) - LOC_W'(min_loc_reg))))
                            begin
                                meta_reg.seg_ways <= meta_reg.seg_ways + LOC_W'(1);
                            end
                            else if ((loc_scaled < shrink_scaled) &&
                                     (meta_reg.seg_ways > LOC_W'(min_loc_reg)))
                            begin
                                meta_reg.seg_ways <= meta_reg.seg_ways - LOC_W'(1);
                            end
                        end
                        loc_hits_reg <= '0;
                        gen_hits_reg <= '0;
                    end
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    // rows go back to memory; a query waits here for the output register
                    if (cmd_reg == CMD_QUERY)
                    begin
                        if (out_load)
                        begin
                            out_valid_reg  <= 1'b1;
                            victim_way_reg <= victim_reg;
                            state_reg      <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign victim_way = victim_way_reg;
    assign cfg_ready  = 1'b1;

    // an accepted item always goes on to load its set rows
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_LOAD))
        else $error("accepted item did not start a set load");

    // the segment boundary never passes the way count
    a_bound_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> (meta_reg.seg_ways <= LOC_W'(NUM_WAYS)))
        else $error("locality way count out of range");

    // stamp scan stays inside its segment
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_idx_reg <= scan_hi_reg))
        else $error("stamp scan index past segment end");

    // a result only follows a query
    a_result_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd_reg == CMD_QUERY))
        else $error("result produced by an update");

endmodule

>>> tb/segmented_rrip_cache_replacement_unit_test.sv
// self-checking testbench for the segmented rrip replacement unit
`timescale 1ns / 1ps

module segmented_rrip_cache_replacement_unit_test;
    import srrip_pkg::*;

    typedef struct {
        logic              cmd;
        logic [SET_W-1:0]  set_idx;
        logic [WAY_W-1:0]  way_idx;
        logic [63:0]       addr;
        logic              hit;
    } access_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              command = CMD_QUERY;
    logic [SET_W-1:0]  set_index = '0;
    logic [WAY_W-1:0]  way_index = '0;
    logic [63:0]       phys_address = '0;
    logic              was_hit = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [WAY_W-1:0]  victim_way;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_index = '0;
    logic [6:0]        cfg_data = '0;

    segmented_rrip_cache_replacement_unit u_top (.*);

    always #1 clk = ~clk;

    // predicted replacement state
    logic [1:0]        pr_rrpv  [NUM_SETS][NUM_WAYS];
    logic [63:0]       pr_stamp [NUM_SETS][NUM_WAYS];
    logic              pr_mark  [NUM_SETS][NUM_WAYS];
    logic [15:0]       pr_page  [NUM_SETS][HIST_DEPTH];
    logic [7:0]        pr_ptr   [NUM_SETS][HIST_DEPTH];
    logic              pr_ptr_ok[NUM_SETS][HIST_DEPTH];
    int unsigned       pr_slot  [NUM_SETS];
    int unsigned       pr_loc   [NUM_SETS];
    logic [63:0]       pr_accesses;
    logic [31:0]       pr_loc_hits;
    logic [31:0]       pr_gen_hits;
    logic [1:0]        ins_rrpv = 2'd2;
    logic [6:0]        grow_pct = 7'd70;
    logic [6:0]        shrink_pct = 7'd30;
    logic [4:0]        period_log2 = 5'd12;
    logic [2:0]        min_loc = 3'd2;

    access_t           pending_q[$];
    logic [WAY_W-1:0]  victim_q[$];
    int                errors = 0;
    int                cycles = 0;
    bit                calm = 0;
    int                in_gap = 0;
    int                out_gap = 0;
    bit                taken;
    access_t           nxt;

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("mismatch at %0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
        errors++;
    endtask

    function automatic int find_top(int s, int lo, int hi);
        for (int w = lo; w < hi; w++)
            if (pr_rrpv[s][w] == RRPV_TOP) return w;
        return -1;
    endfunction

    function automatic int top_in_segments(int s, int l);
        int v;
        v = find_top(s, l, NUM_WAYS);
        if (v < 0) v = find_top(s, 0, l);
        return v;
    endfunction

    function automatic int oldest_in(int s, int lo, int hi);
        int best;
        best = lo;
        for (int w = lo + 1; w < hi; w++)
            if (pr_stamp[s][w] < pr_stamp[s][best]) best = w;
        return best;
    endfunction

    function automatic void swap_meta(int s, int a, int b);
        logic [1:0]  r;
        logic [63:0] t;
        logic        m;
        r = pr_rrpv[s][a]; t = pr_stamp[s][a]; m = pr_mark[s][a];
        pr_rrpv[s][a] = pr_rrpv[s][b];
        pr_stamp[s][a] = pr_stamp[s][b];
        pr_mark[s][a] = pr_mark[s][b];
        pr_rrpv[s][b] = r; pr_stamp[s][b] = t; pr_mark[s][b] = m;
    endfunction

    // apply one accepted item to the predicted state
    task automatic predict_access(input access_t it);
        int s, l, v, w, h, cnt, mn;
        bit loc;
        logic [15:0] page;
        logic [7:0] ptr;
        longint unsigned hl, tot;
        logic [63:0] mask;
        s = it.set_idx;
        w = it.way_idx;
        pr_accesses++;
        l = (pr_loc[s] > NUM_WAYS) ? NUM_WAYS : pr_loc[s];
        if (it.cmd == CMD_QUERY)
        begin
            v = top_in_segments(s, l);
            if (v < 0)
            begin
                for (int k = 0; k < NUM_WAYS; k++)
                    if (pr_rrpv[s][k] < RRPV_TOP) pr_rrpv[s][k]++;
                v = top_in_segments(s, l);
            end
            if (v < 0) v = oldest_in(s, 0, NUM_WAYS);
            victim_q.push_back(v[WAY_W-1:0]);
            return;
        end
        page = it.addr[27:12];
        ptr = it.addr[10:3];
        loc = 0;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            if (pr_page[s][i] == page) loc = 1;
            if (pr_ptr_ok[s][i] && pr_ptr[s][i] == ptr) loc = 1;
        end
        h = pr_slot[s] % HIST_DEPTH;
        pr_page[s][h] = page;
        pr_ptr[s][h] = ptr;
        pr_ptr_ok[s][h] = 1;
        pr_slot[s] = (h + 1) % HIST_DEPTH;
        pr_rrpv[s][w] = it.hit ? 2'd0 : ins_rrpv;
        pr_stamp[s][w] = pr_accesses;
        pr_mark[s][w] = loc;
        if (it.hit)
        begin
            if (loc) pr_loc_hits++;
            else pr_gen_hits++;
        end
        // move the block into the segment of its class
        if (loc && w >= l)
        begin
            if (l > 0) swap_meta(s, w, oldest_in(s, 0, l));
        end
        else if (!loc && w < l)
        begin
            if (l < NUM_WAYS) swap_meta(s, w, oldest_in(s, l, NUM_WAYS));
        end
        // periodic boundary adjustment
        mask = (64'd1 << period_log2) - 64'd1;
        if ((pr_accesses & mask) == 0)
        begin
            hl = pr_loc_hits;
            tot = hl + pr_gen_hits;
            if (tot > 0)
            begin
                cnt = pr_loc[s];
                mn = min_loc;
                if (hl * 100 > grow_pct * tot && cnt < NUM_WAYS - mn) pr_loc[s]++;
                else if (hl * 100 < shrink_pct * tot && cnt > mn) pr_loc[s]--;
            end
            pr_loc_hits = 0;
            pr_gen_hits = 0;
        end
    endtask

    // item driver
    always @(posedge clk)
    begin
        taken = in_valid && !in_stall;
        if (taken) predict_access(nxt);
        if (!in_valid || taken)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0 && rst_n)
            begin
                nxt = pending_q.pop_front();
                command <= nxt.cmd;
                set_index <= nxt.set_idx;
                way_index <= nxt.way_idx;
                phys_address <= nxt.addr;
                was_hit <= nxt.hit;
                in_valid <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 14);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (victim_q.size() == 0) report_mismatch("unexpected victim_way", -1, victim_way);
            else if (victim_q[0] !== victim_way)
            begin
                report_mismatch("victim_way", victim_q[0], victim_way);
                void'(victim_q.pop_front());
            end
            else void'(victim_q.pop_front());
        end
        if (out_gap > 0)
        begin
            out_gap--;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            out_gap = $urandom_range(0, 13);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 1000000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [6:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_INSERT_RRPV: ins_rrpv = val[1:0];
            CFG_GROW_PCT:    grow_pct = val;
            CFG_SHRINK_PCT:  shrink_pct = val;
            CFG_PERIOD_LOG2: period_log2 = val[4:0];
            CFG_MIN_LOC:     min_loc = val[2:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [1:0] ins, input logic [6:0] grow,
                             input logic [6:0] shrink, input logic [4:0] per,
                             input logic [2:0] mn);
        cfg_write(CFG_INSERT_RRPV, {5'd0, ins});
        cfg_write(CFG_GROW_PCT, grow);
        cfg_write(CFG_SHRINK_PCT, shrink);
        cfg_write(CFG_PERIOD_LOG2, {2'd0, per});
        cfg_write(CFG_MIN_LOC, {4'd0, mn});
    endtask

    function automatic access_t make_access(input logic cmd, input int s, input int w,
                                            input logic [63:0] a, input logic h);
        access_t it;
        it.cmd = cmd; it.set_idx = SET_W'(s); it.way_idx = WAY_W'(w); it.addr = a; it.hit = h;
        return it;
    endfunction

    // random item biased toward a few hot sets and a small address pool
    function automatic access_t random_access();
        int s;
        logic [63:0] a;
        s = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 3) * 517 : $urandom_range(0, 2047);
        a = {$urandom, $urandom};
        if ($urandom_range(0, 2) != 0) a[27:12] = 16'($urandom_range(0, 11));
        if ($urandom_range(0, 2) != 0) a[10:3] = 8'($urandom_range(0, 11));
        return make_access($urandom_range(0, 4) < 2 ? CMD_QUERY : CMD_UPDATE, s,
                           $urandom_range(0, 15), a, 1'($urandom_range(0, 1)));
    endfunction

    task automatic drain();
        do @(posedge clk);
        while (pending_q.size() > 0 || in_valid || victim_q.size() > 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        repeat (n) pending_q.push_back(random_access());
        drain();
    endtask

    initial
    begin
        for (int s = 0; s < NUM_SETS; s++)
        begin
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                pr_rrpv[s][w] = RRPV_TOP;
                pr_stamp[s][w] = '0;
                pr_mark[s][w] = 1'b0;
            end
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                pr_page[s][i] = '0;
                pr_ptr[s][i] = '0;
                pr_ptr_ok[s][i] = 1'b0;
            end
            pr_slot[s] = 0;
            pr_loc[s] = INIT_LOC;
        end
        pr_accesses = '0;
        pr_loc_hits = '0;
        pr_gen_hits = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset-state queries, field extremes, all-hit set forcing stamp fallback
        pending_q.push_back(make_access(CMD_QUERY, 0, 0, '0, 1'b0));
        pending_q.push_back(make_access(CMD_QUERY, 2047, 15, '1, 1'b1));
        pending_q.push_back(make_access(CMD_UPDATE, 0, 0, '0, 1'b0));
        pending_q.push_back(make_access(CMD_UPDATE, 2047, 15, '1, 1'b1));
        pending_q.push_back(make_access(CMD_UPDATE, 0, 15, 64'h0000_0000_0000_0008, 1'b1));
        for (int w = 0; w < NUM_WAYS; w++)
            pending_q.push_back(make_access(CMD_UPDATE, 9, w, 64'(w) << 20, 1'b1));
        pending_q.push_back(make_access(CMD_QUERY, 9, 0, '0, 1'b0));
        pending_q.push_back(make_access(CMD_QUERY, 9, 0, '0, 1'b0));
        pending_q.push_back(make_access(CMD_QUERY, 0, 0, '0, 1'b0));
        drain();
        random_phase(250);

        // segment grows whenever locality hits were seen, checked every second access, misses inserted at rrpv zero
        configure(2'd0, 7'd0, 7'd100, 5'd1, 3'd1);
        random_phase(400);
        // segment shrinks, check on every access
        configure(2'd3, 7'd127, 7'd127, 5'd0, 3'd7);
        random_phase(400);
        configure(2'd1, 7'd50, 7'd50, 5'd3, 3'd3);
        random_phase(400);
        // last stretch without idling
        configure(2'd2, 7'd100, 7'd0, 5'd31, 3'd0);
        calm = 1;
        random_phase(380);

        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
design/srrip_pkg.sv
design/srrip_ram.sv
design/srrip_hist.sv
design/segmented_rrip_cache_replacement_unit.sv
tb/segmented_rrip_cache_replacement_unit_test.sv
